>>> design/rrfd_pkg.sv
// ----------------------------------------------------------------------------
// rrfd_pkg
// Shared types and constants for the receive-ring frame deframer.
// ----------------------------------------------------------------------------
package rrfd_pkg;

	// ring geometry and frame limits
	localparam int unsigned RING_BYTES    = 8192;
	localparam int unsigned OFFSET_W      = 13;
	localparam int unsigned MAX_FRAME_DEF = 1792;
	localparam int unsigned HDR_BYTES     = 4;
	localparam int unsigned ACK_BACKOFF   = 16;

	// field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 11;
	localparam int unsigned WORD_W   = 16;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned OUT_W    = 64;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [LEN_W-1:0] LIMIT_RESET = 11'd1514;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLED    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIVER_LIMIT = 1'b1;

	// result kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_END     = 2'd1,
		KIND_BAD     = 2'd2
	} kind_t;

	// parse phase
	typedef enum logic {
		PH_HEADER = 1'b0,
		PH_BODY   = 1'b1
	} phase_t;

	// header byte positions
	localparam logic [1:0] HDR_STATUS_LO = 2'd0;
	localparam logic [1:0] HDR_STATUS_HI = 2'd1;
	localparam logic [1:0] HDR_LEN_LO    = 2'd2;
	localparam logic [1:0] HDR_LEN_HI    = 2'd3;

	// one result item
	typedef struct packed {
		kind_t                kind;
		logic [BYTE_W-1:0]    data;
		logic                 last_payload;
		logic [LEN_W-1:0]     delivered_length;
		logic [WORD_W-1:0]    frame_status;
		logic [OFFSET_W-1:0]  ring_offset;
		logic [WORD_W-1:0]    ack_pointer;
	} res_t;

endpackage

>>> design/rx_ring_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// rx_ring_frame_deframer_core
// A ring byte is held in the input register, parsed, and any result item that it
// gives is held in the result register. Throughput: one byte per cycle while the
// result slot is free, set by the single-pass parse between the two registers.
// Reset: arst_n clears the frame state to the header phase, offset zero,
// rx_enabled to 0 and deliver_limit to 1514; both registers come up empty.
// ----------------------------------------------------------------------------
module rx_ring_frame_deframer_core #(
	parameter int unsigned MAX_FRAME = rrfd_pkg::MAX_FRAME_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rrfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rrfd_pkg::LEN_W-1:0]     cfg_data,
	// ring bytes in
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [rrfd_pkg::BYTE_W-1:0]    s_axis_tdata,  // ring_byte[7:0]
	// results out
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// data[7:0], delivered_length[18:8], frame_status[34:19],
	// ring_offset[47:35], ack_pointer[63:48]
	output logic [rrfd_pkg::OUT_W-1:0]     m_axis_tdata,
	output logic                           m_axis_tlast,  // last_payload
	output logic [rrfd_pkg::KIND_W-1:0]    m_axis_tuser   // kind[1:0]
);
	import rrfd_pkg::*;

	logic              rx_enabled_q;
	logic [LEN_W-1:0]  deliver_limit_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_free;
	logic              step;
	logic              res_valid;
	res_t              res;
	res_t              res_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_enabled_q    <= 1'b0;
			deliver_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RX_ENABLED:    rx_enabled_q    <= cfg_data[0];
				CFG_DELIVER_LIMIT: deliver_limit_q <= cfg_data;
				default:           rx_enabled_q    <= rx_enabled_q;
			endcase
		end
	end

	// a held byte moves on whenever the result slot can take its outcome
	assign step = valid_s1 && out_free;

	rrfd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.advance  (step),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	rrfd_parse #(
		.MAX_FRAME (MAX_FRAME)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.byte_s1       (byte_s1),
		.rx_enabled    (rx_enabled_q),
		.deliver_limit (deliver_limit_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	rrfd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid && step),
		.res_in    (res),
		.free      (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res_q     (res_q)
	);

	// pack the result item
	assign m_axis_tdata = {res_q.ack_pointer, res_q.ring_offset, res_q.frame_status,
		res_q.delivered_length, res_q.data};
	assign m_axis_tlast = res_q.last_payload;
	assign m_axis_tuser = res_q.kind;

endmodule

>>> design/rrfd_in_reg.sv
// ----------------------------------------------------------------------------
// rrfd_in_reg
// Input register for ring bytes; releases its item when the parser steps.
// ----------------------------------------------------------------------------
module rrfd_in_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rrfd_pkg::BYTE_W-1:0] in_byte,
	input  logic                        advance,
	output logic                        valid_s1,
	output logic [rrfd_pkg::BYTE_W-1:0] byte_s1
);
	import rrfd_pkg::*;

	logic valid_q;

	// free when empty or when the held item leaves this cycle
	assign in_ready = !valid_q || advance;
	assign valid_s1 = valid_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
		end else if (advance) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

>>> design/rrfd_parse.sv
// ----------------------------------------------------------------------------
// rrfd_parse
// Frame state and the per-byte header/body decision for the deframer.
// ----------------------------------------------------------------------------
module rrfd_parse #(
	parameter int unsigned MAX_FRAME = rrfd_pkg::MAX_FRAME_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [rrfd_pkg::BYTE_W-1:0] byte_s1,
	input  logic                        rx_enabled,
	input  logic [rrfd_pkg::LEN_W-1:0]  deliver_limit,
	output logic                        res_valid,
	output rrfd_pkg::res_t              res
);
	import rrfd_pkg::*;

	localparam int unsigned SUM_W = OFFSET_W + 4;

	phase_t               phase_q;
	logic [1:0]           hdr_cnt_q;
	logic [WORD_W-1:0]    status_q;
	logic [WORD_W-1:0]    length_q;
	logic [LEN_W-1:0]     body_cnt_q;
	logic [OFFSET_W-1:0]  offset_q;

	phase_t               phase_d;
	logic [1:0]           hdr_cnt_d;
	logic [WORD_W-1:0]    status_d;
	logic [WORD_W-1:0]    length_d;
	logic [LEN_W-1:0]     body_cnt_d;
	logic [OFFSET_W-1:0]  offset_d;

	logic                 en;
	logic [WORD_W-1:0]    len_full;
	logic                 hdr_bad;
	logic [LEN_W-1:0]     pay_len;
	logic [LEN_W-1:0]     pay_cnt;
	logic [LEN_W:0]       total;
	logic [LEN_W:0]       cnt_next;
	logic [SUM_W-1:0]     off_sum;
	logic [OFFSET_W-1:0]  off_next;

	assign en = step && rx_enabled;

	// header check on the final header byte
	assign len_full = {byte_s1, length_q[BYTE_W-1:0]};
	assign hdr_bad  = !status_q[0] || (len_full < WORD_W'(HDR_BYTES))
		|| (len_full > WORD_W'(MAX_FRAME));

	// payload count is min(length - 4, limit); body length rounds up to four
	assign pay_len  = length_q[LEN_W-1:0] - LEN_W'(HDR_BYTES);
	assign pay_cnt  = (pay_len > deliver_limit) ? deliver_limit : pay_len;
	assign total    = ({1'b0, length_q[LEN_W-1:0]} + (LEN_W+1)'(3)) & ~(LEN_W+1)'(3);
	assign cnt_next = {1'b0, body_cnt_q} + (LEN_W+1)'(1);

	// new ring offset, one wrap at most
	assign off_sum  = SUM_W'(offset_q) + SUM_W'(HDR_BYTES) + SUM_W'(total);
	assign off_next = (off_sum >= SUM_W'(RING_BYTES))
		? OFFSET_W'(off_sum - SUM_W'(RING_BYTES)) : OFFSET_W'(off_sum);

	// next state and result
	always_comb begin
		phase_d    = phase_q;
		hdr_cnt_d  = hdr_cnt_q;
		status_d   = status_q;
		length_d   = length_q;
		body_cnt_d = body_cnt_q;
		offset_d   = offset_q;
		res_valid  = 1'b0;
		res        = '0;
		if (en) begin
			if (phase_q == PH_HEADER) begin
				hdr_cnt_d = hdr_cnt_q + 2'd1;
				case (hdr_cnt_q)
					HDR_STATUS_LO: status_d = WORD_W'(byte_s1);
					HDR_STATUS_HI: status_d = {byte_s1, status_q[BYTE_W-1:0]};
					HDR_LEN_LO:    length_d = WORD_W'(byte_s1);
					HDR_LEN_HI: begin
						length_d = len_full;
						if (hdr_bad) begin
							res_valid        = 1'b1;
							res.kind         = KIND_BAD;
							res.frame_status = status_q;
							res.ring_offset  = offset_q;
							res.ack_pointer  = WORD_W'(offset_q) - WORD_W'(ACK_BACKOFF);
						end else begin
							phase_d    = PH_BODY;
							body_cnt_d = '0;
						end
					end
					default: hdr_cnt_d = hdr_cnt_q;
				endcase
			end else if (body_cnt_q < pay_cnt) begin
				// delivered payload byte
				res_valid        = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.data         = byte_s1;
				res.last_payload = (cnt_next == (LEN_W+1)'(pay_cnt));
				body_cnt_d       = cnt_next[LEN_W-1:0];
			end else if (cnt_next >= total) begin
				// final byte of the frame
				res_valid            = 1'b1;
				res.kind             = KIND_END;
				res.delivered_length = pay_cnt;
				res.frame_status     = status_q;
				res.ring_offset      = off_next;
				res.ack_pointer      = WORD_W'(off_next) - WORD_W'(ACK_BACKOFF);
				offset_d             = off_next;
				phase_d              = PH_HEADER;
				body_cnt_d           = '0;
			end else begin
				// surplus payload, crc or padding
				body_cnt_d = cnt_next[LEN_W-1:0];
			end
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_cnt_q  <= '0;
			status_q   <= '0;
			length_q   <= '0;
			body_cnt_q <= '0;
			offset_q   <= '0;
		end else begin
			phase_q    <= phase_d;
			hdr_cnt_q  <= hdr_cnt_d;
			status_q   <= status_d;
			length_q   <= length_d;
			body_cnt_q <= body_cnt_d;
			offset_q   <= offset_d;
		end
	end

	// a result only comes from an enabled step
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (step && rx_enabled))
		else $error("rrfd_parse: result without an enabled step");

	// payload bytes only in the body
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == KIND_PAYLOAD) |-> (phase_q == PH_BODY))
		else $error("rrfd_parse: payload outside the body");

	// frame end returns to a fresh header
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == KIND_END) |=>
		(phase_q == PH_HEADER && body_cnt_q == '0 && hdr_cnt_q == '0))
		else $error("rrfd_parse: frame end did not restart the header");

	// no result on the first three header bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER && hdr_cnt_q != HDR_LEN_HI) |-> !res_valid)
		else $error("rrfd_parse: result before the header was complete");

endmodule

>>> design/rrfd_out_reg.sv
// ----------------------------------------------------------------------------
// rrfd_out_reg
// Result register; holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module rrfd_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  rrfd_pkg::res_t res_in,
	output logic           free,
	output logic           out_valid,
	input  logic           out_ready,
	output rrfd_pkg::res_t res_q
);
	import rrfd_pkg::*;

	logic valid_q;

	// the slot can be refilled when empty or drained this cycle
	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res_in;
		end
	end

endmodule

>>> bench/rrfd_checker.sv
// ----------------------------------------------------------------------------
// rrfd_checker
// Watches the config, ring byte and result channels of the deframer, keeps its
// own copy of the parse state and settings, predicts the result item of each
// accepted ring byte and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module rrfd_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [rrfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rrfd_pkg::LEN_W-1:0]     cfg_data,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [rrfd_pkg::BYTE_W-1:0]    s_axis_tdata,  // ring_byte[7:0]
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// data[7:0], delivered_length[18:8], frame_status[34:19],
	// ring_offset[47:35], ack_pointer[63:48]
	input  logic [rrfd_pkg::OUT_W-1:0]     m_axis_tdata,
	input  logic                           m_axis_tlast,  // last_payload
	input  logic [rrfd_pkg::KIND_W-1:0]    m_axis_tuser,  // kind[1:0]
	output int                             pending,
	output int                             errors
);
	timeunit 1ns;
	timeprecision 1ps;
	import rrfd_pkg::*;

	// bit positions of the result fields in tdata
	localparam int unsigned DL_LSB = BYTE_W;
	localparam int unsigned FS_LSB = DL_LSB + LEN_W;
	localparam int unsigned RO_LSB = FS_LSB + WORD_W;
	localparam int unsigned AP_LSB = RO_LSB + OFFSET_W;

	// mirrored settings and parse state
	logic                rx_enabled_q;
	logic [LEN_W-1:0]    deliver_cap;
	phase_t              frm_phase;
	logic [1:0]          hdr_idx;
	logic [WORD_W-1:0]   hdr_status;
	logic [WORD_W-1:0]   hdr_length;
	logic [LEN_W-1:0]    body_idx;
	logic [OFFSET_W-1:0] rd_offset;

	res_t expected_results[$];

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("%0t ns: %0s mismatch, got 0x%0h, expected 0x%0h",
			$realtime, what, got, want);
		errors++;
	endtask

	// parse one ring byte, advance the mirrored state, give the result item if any
	task automatic deframe_byte(input logic [BYTE_W-1:0] b, output bit made,
			output res_t r);
		int unsigned pay;
		int unsigned span;
		int unsigned nxt;
		made = 1'b0;
		r    = '0;
		if (!rx_enabled_q)
			return;
		if (frm_phase == PH_HEADER) begin
			case (hdr_idx)
				HDR_STATUS_LO: hdr_status = {8'h00, b};
				HDR_STATUS_HI: hdr_status[15:8] = b;
				HDR_LEN_LO:    hdr_length = {8'h00, b};
				default:       hdr_length[15:8] = b;
			endcase
			if (hdr_idx != HDR_LEN_HI) begin
				hdr_idx++;
				return;
			end
			hdr_idx = HDR_STATUS_LO;
			// bad header: offset stays, next byte opens a new header
			if (!hdr_status[0] || hdr_length < HDR_BYTES || hdr_length > MAX_FRAME_DEF) begin
				made           = 1'b1;
				r.kind         = KIND_BAD;
				r.frame_status = hdr_status;
				r.ring_offset  = rd_offset;
				r.ack_pointer  = 16'(rd_offset - ACK_BACKOFF);
				return;
			end
			frm_phase = PH_BODY;
			body_idx  = '0;
			return;
		end

		// body: payload up to the cap, then the rest of the padded body
		pay = hdr_length - HDR_BYTES;
		if (pay > deliver_cap)
			pay = deliver_cap;
		span = (hdr_length + HDR_BYTES - 1) & ~(HDR_BYTES - 1);
		if (body_idx < pay) begin
			made           = 1'b1;
			r.kind         = KIND_PAYLOAD;
			r.data         = b;
			r.last_payload = (body_idx + 1 == pay);
			body_idx++;
			return;
		end
		if (body_idx + 1 >= span) begin
			nxt                = (rd_offset + HDR_BYTES + span) % RING_BYTES;
			rd_offset          = nxt[OFFSET_W-1:0];
			frm_phase          = PH_HEADER;
			body_idx           = '0;
			made               = 1'b1;
			r.kind             = KIND_END;
			r.delivered_length = pay[LEN_W-1:0];
			r.frame_status     = hdr_status;
			r.ring_offset      = rd_offset;
			r.ack_pointer      = 16'(rd_offset - ACK_BACKOFF);
			return;
		end
		body_idx++;
	endtask

	// monitor all three channels
	always @(posedge clk or negedge arst_n) begin : monitor
		res_t seen;
		res_t want;
		res_t fresh;
		bit   made;
		if (!arst_n) begin
			rx_enabled_q = 1'b0;
			deliver_cap  = LIMIT_RESET;
			frm_phase    = PH_HEADER;
			hdr_idx      = HDR_STATUS_LO;
			hdr_status   = '0;
			hdr_length   = '0;
			body_idx     = '0;
			rd_offset    = '0;
			expected_results.delete();
			errors       = 0;
			pending     <= 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RX_ENABLED:    rx_enabled_q = cfg_data[0];
					CFG_DELIVER_LIMIT: deliver_cap  = cfg_data;
					default: ;
				endcase
			end
			// result items against the oldest expectation
			if (m_axis_tvalid && m_axis_tready) begin
				seen.kind             = kind_t'(m_axis_tuser);
				seen.data             = m_axis_tdata[BYTE_W-1:0];
				seen.last_payload     = m_axis_tlast;
				seen.delivered_length = m_axis_tdata[DL_LSB +: LEN_W];
				seen.frame_status     = m_axis_tdata[FS_LSB +: WORD_W];
				seen.ring_offset      = m_axis_tdata[RO_LSB +: OFFSET_W];
				seen.ack_pointer      = m_axis_tdata[AP_LSB +: WORD_W];
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result, kind", seen.kind, '0);
				end else begin
					want = expected_results.pop_front();
					if (seen.kind !== want.kind)
						report_mismatch("kind", seen.kind, want.kind);
					if (seen.data !== want.data)
						report_mismatch("data", seen.data, want.data);
					if (seen.last_payload !== want.last_payload)
						report_mismatch("last_payload", seen.last_payload, want.last_payload);
					if (seen.delivered_length !== want.delivered_length)
						report_mismatch("delivered_length", seen.delivered_length,
							want.delivered_length);
					if (seen.frame_status !== want.frame_status)
						report_mismatch("frame_status", seen.frame_status, want.frame_status);
					if (seen.ring_offset !== want.ring_offset)
						report_mismatch("ring_offset", seen.ring_offset, want.ring_offset);
					if (seen.ack_pointer !== want.ack_pointer)
						report_mismatch("ack_pointer", seen.ack_pointer, want.ack_pointer);
				end
			end
			// ring bytes in
			if (s_axis_tvalid && s_axis_tready) begin
				deframe_byte(s_axis_tdata, made, fresh);
				if (made)
					expected_results.push_back(fresh);
			end
			pending <= expected_results.size();
		end
	end

endmodule

>>> bench/tb_rx_ring_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_rx_ring_frame_deframer_core
// Feeds receive-ring byte streams into the deframer: directed headers and
// frames first, then random frames and bad headers under several settings,
// and a long output hold-off that stalls the input.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_rx_ring_frame_deframer_core ();
	timeunit 1ns;
	timeprecision 1ps;
	import rrfd_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned PHASE_ITEMS   = 85;
	localparam int unsigned RAND_PHASES   = 6;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = CFG_RX_ENABLED;
	logic [LEN_W-1:0]     cfg_data      = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [BYTE_W-1:0]    s_axis_tdata  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_W-1:0]     m_axis_tdata;
	logic                 m_axis_tlast;
	logic [KIND_W-1:0]    m_axis_tuser;

	int          pending;
	int          errors;
	int unsigned cycles     = 0;
	bit          src_idle   = 1'b1;
	bit          sink_idle  = 1'b1;
	int          hold_reqs  = 0;
	bit          rx_live    = 1'b0;
	logic [LEN_W-1:0] cur_limit = LIMIT_RESET;
	int unsigned fed        = 0;

	rx_ring_frame_deframer_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	rrfd_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.pending       (pending),
		.errors        (errors)
	);

	// clock
	always #5 clk = ~clk;

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL rx_ring_frame_deframer_core");
			$finish;
		end
	end

	// result sink: random stalls, plus a long hold-off on request
	initial begin : sink
		int unsigned stall;
		int          holds_done;
		holds_done = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = sink_idle ? $urandom_range(0, 16) : 0;
			if (holds_done != hold_reqs) begin
				stall = HOLD_CYCLES;
				holds_done++;
			end
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// one ring byte, after a random gap when src_idle is set
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 16) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		if (rx_live)
			fed++;
	endtask

	// stop feeding and wait until every expected result has come out
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers back to back, block idle
	task automatic program_regs(input logic en, input logic [LEN_W-1:0] lim);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_RX_ENABLED;
		cfg_data  <= LEN_W'(en);
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_index <= CFG_DELIVER_LIMIT;
		cfg_data  <= lim;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		rx_live   = en;
		cur_limit = lim;
	endtask

	// switch the receiver off for a few junk bytes, frame state must survive
	task automatic rx_pause();
		settle();
		program_regs(1'b0, cur_limit);
		repeat (3) send_byte(8'($urandom));
		settle();
		program_regs(1'b1, cur_limit);
	endtask

	// header, then the whole padded body when the header is good
	task automatic send_frame(input logic [WORD_W-1:0] status,
			input logic [WORD_W-1:0] length, input int pause_at);
		int span;
		send_byte(status[7:0]);
		send_byte(status[15:8]);
		send_byte(length[7:0]);
		send_byte(length[15:8]);
		if (!status[0] || length < HDR_BYTES || length > MAX_FRAME_DEF)
			return;
		span = (int'(length) + HDR_BYTES - 1) & ~(HDR_BYTES - 1);
		for (int i = 0; i < span; i++) begin
			if (i == pause_at)
				rx_pause();
			send_byte(8'($urandom));
		end
	endtask

	initial begin : stim
		logic [WORD_W-1:0] status;
		logic [WORD_W-1:0] length;
		logic [LEN_W-1:0]  lim;
		int unsigned       pick;
		int unsigned       target;
		int                pause_at;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// receiver still off after reset: bytes vanish
		send_byte(8'hA5);
		send_byte(8'h5A);
		settle();
		program_regs(1'b1, LIMIT_RESET);

		// status bit clear and zero length at offset zero, ack pointer wraps
		send_frame(16'h0000, 16'h0000, -1);
		// length of exactly four: crc only
		send_frame(16'hFFFF, 16'(HDR_BYTES), -1);
		// just over the longest frame, and just under the header size
		send_frame(16'h0001, 16'(MAX_FRAME_DEF + 1), -1);
		send_frame(16'h0001, 16'(HDR_BYTES - 1), -1);
		// short payload with padding
		send_frame(16'h8001, 16'd7, -1);
		// receiver off in the middle of a header
		send_byte(8'h01);
		send_byte(8'h00);
		rx_pause();
		send_byte(8'h0C);
		send_byte(8'h00);
		repeat (12) send_byte(8'($urandom));
		// receiver off in the middle of the payload
		send_frame(16'h0003, 16'd10, 3);

		// random frames under several settings
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			case (ph)
				0:       lim = 11'd1;
				1:       lim = 11'd2047;
				2:       lim = 11'd0;
				3:       lim = 11'($urandom_range(1, 24));
				4:       lim = 11'($urandom_range(1, 2047));
				default: lim = LIMIT_RESET;
			endcase
			src_idle  = ($urandom_range(0, 3) != 0);
			sink_idle <= ($urandom_range(0, 3) != 0);
			program_regs(1'b1, lim);
			target = fed + PHASE_ITEMS;
			while (fed < target) begin
				pick     = $urandom_range(0, 99);
				status   = 16'($urandom);
				length   = 16'($urandom);
				pause_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8) : -1;
				if (pick < 70) begin
					// well-formed frame, mostly short
					status[0] = 1'b1;
					pick = $urandom_range(0, 99);
					if (pick < 60)
						length = 16'($urandom_range(HDR_BYTES, 24));
					else if (pick < 90)
						length = 16'($urandom_range(25, 100));
					else
						length = 16'($urandom_range(101, 300));
				end else if (pick < 78) begin
					status[0] = 1'b0;
				end else if (pick < 84) begin
					length = 16'($urandom_range(0, HDR_BYTES - 1));
				end else if (pick < 92) begin
					length = 16'($urandom_range(MAX_FRAME_DEF + 1, 16'hFFFF));
				end
				send_frame(status, length, pause_at);
			end
		end

		// frame fully delivered, output held off so the input stalls
		settle();
		src_idle  = 1'b0;
		sink_idle <= 1'b1;
		program_regs(1'b1, 11'd2047);
		hold_reqs <= hold_reqs + 1;
		send_frame(16'h0001 | 16'($urandom), 16'd100, -1);

		settle();
		if (errors == 0)
			$display("PASS rx_ring_frame_deframer_core");
		else
			$display("FAIL rx_ring_frame_deframer_core");
		$finish;
	end

endmodule

>>> rx_ring_frame_deframer_core.f
design/rrfd_pkg.sv
design/rrfd_in_reg.sv
design/rrfd_parse.sv
design/rrfd_out_reg.sv
design/rx_ring_frame_deframer_core.sv
bench/rrfd_checker.sv
bench/tb_rx_ring_frame_deframer_core.sv
